### rtl/core/hex2utf8_pkg.sv
// ----------------------------------------------------------------------------
// hex2utf8_pkg
// Shared types and constants for the escape-to-UTF-8 name decoder.
// ----------------------------------------------------------------------------
package hex2utf8_pkg;

   localparam int CapWidth   = 13;  // capacity register width
   localparam int CountWidth = 12;  // bytes written per name
   localparam int HoldMax    = 5;   // '#', 'U', three hex digits
   localparam int BurstDepth = 6;   // most results one transaction can cause

   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChUpperU = 8'h55;
   localparam logic [7:0] ChLowerU = 8'h75;

   localparam logic [15:0] CpTwoByte   = 16'h0080;
   localparam logic [15:0] CpThreeByte = 16'h0800;
   localparam logic [7:0]  LeadTwo     = 8'hC0;
   localparam logic [7:0]  LeadThree   = 8'hE0;
   localparam logic [7:0]  ContMark    = 8'h80;
   localparam logic [5:0]  ContMask    = 6'h3F;

   localparam logic [CapWidth-1:0]   CapMax       = 13'd4096;
   localparam logic [CountWidth-1:0] LimitMax     = 12'd4095;
   localparam logic [CountWidth-1:0] LimitDefault = 12'd63;   // capacity 64

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_entry_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_nibble(input logic [7:0] ch);
      nibble_type r;
      r.valid = 1'b1;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r.value = 4'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         r.value = 4'(ch - 8'h57);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         r.value = 4'(ch - 8'h37);
      end else begin
         r.valid = 1'b0;
         r.value = 4'd0;
      end
      return r;
   endfunction

endpackage

### rtl/core/hex_escape_to_utf8_decoder.sv
// ----------------------------------------------------------------------------
// hex_escape_to_utf8_decoder
// Replaces '#U'/'#u' + four hex digit escapes in a byte stream by UTF-8.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                  | tuser | tlast
//  req_     | in  | [7:0] in_byte          | -     | is_terminator
//  rsp_     | out | [7:0] out_byte         | -     | end_mark
//  csr_     | in  | [12:0] out_capacity    | -     | -
//
// One transaction is accepted per cycle while the result burst holds at most
// one entry that is leaving; a transaction producing more than one result
// stalls req_ until all but its last have left the result burst register.
// A result passes the burst register, then the output register, on its way
// to rsp_.
// Reset is synchronous; it empties the burst and output register and clears
// escape and name state. rsp_tready low holds the output register.
// ----------------------------------------------------------------------------
module hex_escape_to_utf8_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] in_byte
   input  logic                                 req_tlast,   // is_terminator
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] out_byte
   output logic                                 rsp_tlast,   // end_mark
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hex2utf8_pkg::CapWidth-1:0]    csr_data     // out_capacity
);
   import hex2utf8_pkg::*;

   logic [CountWidth-1:0] limit_ff, limit_in;
   logic [7:0]            held_ff [HoldMax];
   logic [7:0]            held_in [HoldMax];
   logic [2:0]            hcnt_ff, hcnt_in;
   logic [CountWidth-1:0] wcnt_ff, wcnt_in;
   logic                  stopped_ff, stopped_in;

   rsp_entry_type         burst_ff [BurstDepth];
   rsp_entry_type         burst_in [BurstDepth];
   logic [2:0]            burst_cnt_ff, burst_cnt_in;
   rsp_entry_type         rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  burst_move;
   logic [CountWidth-1:0] room;
   logic [2:0]            avail;
   logic                  fits;
   logic [2:0]            len;
   logic [2:0]            keep;
   logic [2:0]            emit_cnt;
   nibble_type            nib [4];
   logic [15:0]           cp;
   logic [2:0]            enc_n;
   logic [7:0]            enc [3];
   rsp_entry_type         list [BurstDepth];

   assign csr_ready  = 1'b1;
   assign burst_move = (burst_cnt_ff != 3'd0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (burst_cnt_ff == 3'd0) || ((burst_cnt_ff == 3'd1) && burst_move);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tlast  = rsp_ff.last;

   // capacity is kept as the byte limit: capacity - 1, clamped to 0..4095
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            limit_in = '0;
         end else if (csr_data > CapMax) begin
            limit_in = LimitMax;
         end else begin
            limit_in = CountWidth'(csr_data - 13'd1);
         end
      end
   end

   // escape decode of held digits plus the incoming byte
   always_comb begin
      nib[0] = hex_nibble(held_ff[2]);
      nib[1] = hex_nibble(held_ff[3]);
      nib[2] = hex_nibble(held_ff[4]);
      nib[3] = hex_nibble(req_tdata);
      cp = {nib[0].value, nib[1].value, nib[2].value, nib[3].value};
      if (cp < CpTwoByte) begin
         enc_n  = 3'd1;
         enc[0] = cp[7:0];
         enc[1] = 8'h00;
         enc[2] = 8'h00;
      end else if (cp < CpThreeByte) begin
         enc_n  = 3'd2;
         enc[0] = LeadTwo | {3'b000, cp[10:6]};
         enc[1] = ContMark | {2'b00, cp[5:0] & ContMask};
         enc[2] = 8'h00;
      end else begin
         enc_n  = 3'd3;
         enc[0] = LeadThree | {4'h0, cp[15:12]};
         enc[1] = ContMark | {2'b00, cp[11:6] & ContMask};
         enc[2] = ContMark | {2'b00, cp[5:0] & ContMask};
      end
   end

   always_comb begin
      room  = (wcnt_ff < limit_ff) ? (limit_ff - wcnt_ff) : '0;
      avail = (room >= CountWidth'(BurstDepth)) ? 3'(BurstDepth) : room[2:0];

      case (hcnt_ff)
         3'd0:    fits = 1'b0;
         3'd1:    fits = (req_tdata == ChUpperU) || (req_tdata == ChLowerU);
         default: fits = nib[3].valid;
      endcase

      len  = hcnt_ff + {2'b00, req_tdata != ChHash};
      keep = (hcnt_ff < avail) ? hcnt_ff : avail;

      held_in    = held_ff;
      hcnt_in    = hcnt_ff;
      wcnt_in    = wcnt_ff;
      stopped_in = stopped_ff;
      emit_cnt   = 3'd0;
      for (int i = 0; i < BurstDepth; i++) begin
         list[i] = '{data: 8'h00, last: 1'b0};
      end

      if (req_tlast) begin
         // flush what fits, end marker right after it
         for (int i = 0; i < BurstDepth; i++) begin
            if (i < HoldMax && 3'(i) < keep) begin
               list[i] = '{data: held_ff[i], last: 1'b0};
            end else if (3'(i) == keep) begin
               list[i] = '{data: 8'h00, last: 1'b1};
            end
         end
         emit_cnt   = keep + 3'd1;
         hcnt_in    = 3'd0;
         wcnt_in    = '0;
         stopped_in = 1'b0;
      end else if (stopped_ff) begin
         hcnt_in = 3'd0;
      end else if (hcnt_ff != 3'd0 && fits) begin
         if (hcnt_ff == 3'(HoldMax)) begin
            hcnt_in = 3'd0;
            if (avail >= enc_n) begin
               for (int i = 0; i < 3; i++) begin
                  list[i] = '{data: enc[i], last: 1'b0};
               end
               emit_cnt = enc_n;
               wcnt_in  = wcnt_ff + CountWidth'(enc_n);
            end else begin
               stopped_in = 1'b1;
            end
         end else begin
            for (int i = 0; i < HoldMax; i++) begin
               if (3'(i) == hcnt_ff) begin
                  held_in[i] = req_tdata;
               end
            end
            hcnt_in = hcnt_ff + 3'd1;
         end
      end else begin
         // pattern broken: held bytes go out literally, then the new byte unless it is '#', which starts a new escape
         for (int i = 0; i < BurstDepth; i++) begin
            if (i < HoldMax && 3'(i) < hcnt_ff) begin
               list[i] = '{data: held_ff[i], last: 1'b0};
            end else begin
               list[i] = '{data: req_tdata, last: 1'b0};
            end
         end
         if (len > avail) begin
            emit_cnt   = avail;
            stopped_in = 1'b1;
            hcnt_in    = 3'd0;
         end else begin
            emit_cnt = len;
            if (req_tdata == ChHash) begin
               held_in[0] = req_tdata;
               hcnt_in    = 3'd1;
            end else begin
               hcnt_in = 3'd0;
            end
         end
         wcnt_in = wcnt_ff + CountWidth'(emit_cnt);
      end
   end

   // result burst: loaded on accept, shifted toward the output register
   always_comb begin
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (burst_move) begin
         rsp_in       = burst_ff[0];
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         burst_in     = list;
         burst_cnt_in = emit_cnt;
      end else if (burst_move) begin
         for (int i = 0; i < BurstDepth - 1; i++) begin
            burst_in[i] = burst_ff[i+1];
         end
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitDefault;
         hcnt_ff      <= 3'd0;
         wcnt_ff      <= '0;
         stopped_ff   <= 1'b0;
         burst_cnt_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         burst_cnt_ff <= burst_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            hcnt_ff    <= hcnt_in;
            wcnt_ff    <= wcnt_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         held_ff <= held_in;
      end
      burst_ff <= burst_in;
      rsp_ff   <= rsp_in;
   end

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= 3'(BurstDepth))
      else $error("result burst count out of range");

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= 3'(HoldMax))
      else $error("held escape count out of range");

   a_stop_empty: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> hcnt_ff == 3'd0)
      else $error("escape bytes held while output stopped");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> burst_cnt_ff <= 3'd1)
      else $error("transaction accepted over pending results");

   a_name_reset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (hcnt_ff == 3'd0 && wcnt_ff == '0 && !stopped_ff))
      else $error("name state not cleared after terminator");

endmodule
